// ===== hdl/lic_pkg.sv =====
// Package for the LRU ID cache table: request/result types, entry type,
// opcodes and controller states. No dependencies.
package lic_pkg;

    localparam int DEPTH_DEF = 64;
    localparam logic [6:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_GET    = 2'd1,
        OP_UNLOAD = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] res_id;
        logic [31:0] now;
    } in_t;

    typedef struct packed {
        logic        found;
        logic [5:0]  slot;
        logic        evicted;
        logic [15:0] evicted_id;
        logic [6:0]  live_count;
    } out_t;

    // One cache entry as it moves along the ring
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] stamp;
    } entry_t;

    // Ring control handed to every cell
    typedef struct packed {
        logic shift;
    } ring_ctl_t;

endpackage

// ===== hdl/lru_id_cache_table.sv =====
// Top level of the LRU ID cache table: entry ring of lic_cell and the
// controller that scans and rewrites it. Depends on lic_pkg, lic_cell.
//
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one request: op, res_id, now.
//   out channel (out_valid/out_ready/out_data) returns one result per request.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes capacity; always ready,
//   write only while idle.
// Entries sit in a ring of DEPTH cells that rotates one place per cycle
// while scanning or rewriting, past the controller at the head; a full
// rotation restores the order. Clear needs no rotation; get takes one
// scan rotation; load and unload take a scan rotation, then a rewrite
// rotation. One request in flight at a time; the next is taken once the
// result has been taken.
// Reset empties the table (count 0) and sets capacity to 64; the entry
// cells hold no reset value and are only read below the count.
// If the receiver stalls, the result holds in the output register and
// in_ready stays low.
module lru_id_cache_table
    import lic_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_t       out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > 7) ? CW : 7;
    localparam logic [IW-1:0] K_LAST = IW'(DEPTH - 1);
    localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);

    // ring
    entry_t    cell_q [DEPTH];
    entry_t    tail_d;
    entry_t    head;
    ring_ctl_t ctl;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_ring
        if (i == DEPTH - 1)
        begin : g_tail
            lic_cell u_cell (.clk(clk), .ctl(ctl), .d(tail_d), .q(cell_q[i]));
        end
        else
        begin : g_mid
            lic_cell u_cell (.clk(clk), .ctl(ctl), .d(cell_q[i+1]), .q(cell_q[i]));
        end
    end
    assign head = cell_q[0];

    // control registers
    state_t        state_reg, state_next;
    logic [IW-1:0] k_reg, k_next;
    logic [CW-1:0] count_reg, count_next;
    logic [6:0]    cap_reg;
    logic          out_valid_reg, out_valid_next;
    out_t          res_reg, res_next;
    in_t           req_reg;

    // scan results
    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [IW-1:0] old_idx_reg, old_idx_next;
    logic [31:0]   old_stamp_reg, old_stamp_next;
    logic [15:0]   old_id_reg, old_id_next;
    entry_t        last_reg, last_next;

    // rewrite plan
    logic          do_ref_reg, do_ref_next;
    logic          do_move_reg, do_move_next;
    logic [IW-1:0] move_idx_reg, move_idx_next;
    logic          do_app_reg, do_app_next;
    logic [IW-1:0] app_idx_reg, app_idx_next;

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        res_reg       <= res_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        old_idx_reg   <= old_idx_next;
        old_stamp_reg <= old_stamp_next;
        old_id_reg    <= old_id_next;
        last_reg      <= last_next;
        do_ref_reg    <= do_ref_next;
        do_move_reg   <= do_move_next;
        move_idx_reg  <= move_idx_next;
        do_app_reg    <= do_app_next;
        app_idx_reg   <= app_idx_next;
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
    end

    // next state, scan and rewrite
    always_comb
    begin
        logic [CW-1:0] kc;
        logic [WW-1:0] cap_eff;
        logic          live;
        logic          evict;
        logic [CW-1:0] newc;
        logic [IW-1:0] vidx;

        state_next     = state_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        old_idx_next   = old_idx_reg;
        old_stamp_next = old_stamp_reg;
        old_id_next    = old_id_reg;
        last_next      = last_reg;
        do_ref_next    = do_ref_reg;
        do_move_next   = do_move_reg;
        move_idx_next  = move_idx_reg;
        do_app_next    = do_app_reg;
        app_idx_next   = app_idx_reg;
        ctl.shift      = 1'b0;
        tail_d         = head;

        kc   = CW'(k_reg);
        live = kc < count_reg;
        if (cap_reg == 7'd0)
        begin
            cap_eff = WW'(1);
        end
        else if (WW'(cap_reg) > DEPTH_W)
        begin
            cap_eff = DEPTH_W;
        end
        else
        begin
            cap_eff = WW'(cap_reg);
        end
        evict = 1'b0;
        newc  = count_reg;
        vidx  = old_idx_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    k_next   = '0;
                    hit_next = 1'b0;
                    if (in_data.op == OP_CLEAR)
                    begin
                        count_next = '0;
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                ctl.shift = 1'b1;
                // first match
                if (live && !hit_reg && head.id == req_reg.res_id)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = k_reg;
                end
                // oldest stamp, lowest index on ties
                if (k_reg == '0)
                begin
                    old_idx_next   = '0;
                    old_stamp_next = head.stamp;
                    old_id_next    = head.id;
                end
                else if (live && head.stamp < old_stamp_reg)
                begin
                    old_idx_next   = k_reg;
                    old_stamp_next = head.stamp;
                    old_id_next    = head.id;
                end
                // last live entry
                if (kc + CW'(1) == count_reg)
                begin
                    last_next = head;
                end
                k_next = k_reg + IW'(1);
                if (k_reg == K_LAST)
                begin
                    k_next        = '0;
                    do_ref_next   = 1'b0;
                    do_move_next  = 1'b0;
                    do_app_next   = 1'b0;
                    res_next      = '0;
                    state_next    = ST_WRITE;
                    // decide with this cycle's scan folded in
                    if (hit_next)
                    begin
                        res_next.found = 1'b1;
                    end
                    case (req_reg.op)
                        OP_LOAD:
                        begin
                            if (hit_next)
                            begin
                                do_ref_next   = 1'b1;
                                res_next.slot = 6'(hit_idx_next);
                            end
                            else
                            begin
                                evict = (WW'(count_reg) >= cap_eff) && (count_reg != '0);
                                vidx  = old_idx_next;
                                if (evict)
                                begin
                                    res_next.evicted    = 1'b1;
                                    res_next.evicted_id = old_id_next;
                                    newc                = count_reg - CW'(1);
                                    do_move_next        = CW'(vidx) + CW'(1) < count_reg;
                                    move_idx_next       = vidx;
                                end
                                if (WW'(newc) < DEPTH_W)
                                begin
                                    do_app_next   = 1'b1;
                                    app_idx_next  = IW'(newc);
                                    res_next.slot = 6'(newc);
                                    newc          = newc + CW'(1);
                                end
                                count_next = newc;
                            end
                        end
                        OP_UNLOAD:
                        begin
                            if (hit_next)
                            begin
                                do_move_next  = CW'(hit_idx_next) + CW'(1) < count_reg;
                                move_idx_next = hit_idx_next;
                                count_next    = count_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                            // get: no rewrite
                            if (hit_next)
                            begin
                                res_next.slot = 6'(hit_idx_next);
                            end
                            state_next = ST_DONE;
                        end
                    endcase
                    res_next.live_count = 7'(count_next);
                end
            end

            ST_WRITE:
            begin
                ctl.shift = 1'b1;
                if (do_ref_reg && k_reg == hit_idx_reg)
                begin
                    tail_d.stamp = req_reg.now;
                end
                if (do_move_reg && k_reg == move_idx_reg)
                begin
                    tail_d = last_reg;
                end
                if (do_app_reg && k_reg == app_idx_reg)
                begin
                    tail_d.id    = req_reg.res_id;
                    tail_d.stamp = req_reg.now;
                end
                k_next = k_reg + IW'(1);
                if (k_reg == K_LAST)
                begin
                    k_next     = '0;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/lic_cell.sv =====
// One storage cell of the entry ring: holds one entry, passes it on.
// Depends on lic_pkg.
module lic_cell
    import lic_pkg::*;
(
    input  logic      clk,
    input  ring_ctl_t ctl,
    input  entry_t    d,
    output entry_t    q
);

    entry_t q_reg;

    // shift toward the head of the ring
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

// ===== sim/lru_id_cache_table_tb.sv =====
// Testbench for lru_id_cache_table: random and directed requests checked
// against an in-bench LRU table predictor. Depends on lic_pkg and the DUT.
module lru_id_cache_table_tb;
    import lic_pkg::*;

    localparam int DEPTH = 64;
    localparam int LIMIT = 2000000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_t        in_data;
    logic       out_valid;
    logic       out_ready;
    out_t       out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;

    lru_id_cache_table #(.DEPTH(DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Predictor state
    logic [15:0] tbl_ids [DEPTH];
    logic [31:0] tbl_stamps [DEPTH];
    int          tbl_count;
    logic [6:0]  tbl_cap;
    out_t        pending_q[$];

    int  errors;
    int  cycles;
    bit  hold_off;
    int  hold_len;
    int  rx_gap;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Run guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int rand_gap();
        if ($urandom_range(0, 9) < 3)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 200);
        return $urandom_range(1, 4);
    endfunction

    // Remove entry idx, last live entry fills the hole
    function automatic void tbl_remove(int idx);
        if (idx + 1 < tbl_count)
        begin
            tbl_ids[idx]    = tbl_ids[tbl_count - 1];
            tbl_stamps[idx] = tbl_stamps[tbl_count - 1];
        end
        tbl_count--;
    endfunction

    // Compute the result of one request and update the table
    function automatic out_t predict_lookup(in_t req);
        out_t r;
        int   hit_idx;
        int   cap;
        int   oldest;
        r = '0;
        hit_idx = -1;
        cap = (tbl_cap < 1) ? 1 : ((tbl_cap > DEPTH) ? DEPTH : int'(tbl_cap));
        for (int i = 0; i < tbl_count; i++)
            if (hit_idx < 0 && tbl_ids[i] == req.res_id)
                hit_idx = i;
        case (req.op)
            OP_LOAD:
            begin
                if (hit_idx >= 0)
                begin
                    tbl_stamps[hit_idx] = req.now;
                    r.found = 1'b1;
                    r.slot  = hit_idx[5:0];
                end
                else
                begin
                    if (tbl_count >= cap && tbl_count > 0)
                    begin
                        oldest = 0;
                        for (int i = 1; i < tbl_count; i++)
                            if (tbl_stamps[i] < tbl_stamps[oldest])
                                oldest = i;
                        r.evicted    = 1'b1;
                        r.evicted_id = tbl_ids[oldest];
                        tbl_remove(oldest);
                    end
                    if (tbl_count < DEPTH)
                    begin
                        tbl_ids[tbl_count]    = req.res_id;
                        tbl_stamps[tbl_count] = req.now;
                        r.slot = tbl_count[5:0];
                        tbl_count++;
                    end
                end
            end
            OP_GET:
            begin
                if (hit_idx >= 0)
                begin
                    r.found = 1'b1;
                    r.slot  = hit_idx[5:0];
                end
            end
            OP_UNLOAD:
            begin
                if (hit_idx >= 0)
                begin
                    r.found = 1'b1;
                    tbl_remove(hit_idx);
                end
            end
            default:
                tbl_count = 0;
        endcase
        r.live_count = tbl_count[6:0];
        return r;
    endfunction

    // Send one request; prediction made at acceptance
    task automatic send_request(op_t op, logic [15:0] id, logic [31:0] stamp);
        int gap;
        in_t req;
        gap = rand_gap();
        // step off the edge where valid was dropped
        repeat (gap + 1) @(negedge clk);
        req.op = op;
        req.res_id = id;
        req.now = stamp;
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_q.push_back(predict_lookup(req));
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Receiver ready pattern, random idle stretches and the long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else if (rx_gap > 0)
        begin
            out_ready <= 1'b0;
            rx_gap    <= rx_gap - 1;
        end
        else if ($urandom_range(0, 49) == 0)
        begin
            out_ready <= 1'b0;
            rx_gap    <= $urandom_range(10, 100);
        end
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (hold_off)
        begin
            hold_len <= hold_len - 1;
            if (hold_len <= 1)
                hold_off <= 1'b0;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        out_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                exp_r = pending_q.pop_front();
                if (out_data.found !== exp_r.found)
                begin
                    $error("found exp %0d got %0d", exp_r.found, out_data.found);
                    errors++;
                end
                if (out_data.slot !== exp_r.slot)
                begin
                    $error("slot exp %0d got %0d", exp_r.slot, out_data.slot);
                    errors++;
                end
                if (out_data.evicted !== exp_r.evicted)
                begin
                    $error("evicted exp %0d got %0d", exp_r.evicted, out_data.evicted);
                    errors++;
                end
                if (out_data.evicted_id !== exp_r.evicted_id)
                begin
                    $error("evicted_id exp %h got %h", exp_r.evicted_id,
                           out_data.evicted_id);
                    errors++;
                end
                if (out_data.live_count !== exp_r.live_count)
                begin
                    $error("live_count exp %0d got %0d", exp_r.live_count,
                           out_data.live_count);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (2 * DEPTH + 10) @(negedge clk);
    endtask

    // Capacity write, only while idle
    task automatic write_capacity(logic [6:0] cap);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tbl_cap = cap;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random id drawn from a small pool most of the time so hits occur
    function automatic logic [15:0] pick_id();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom());
        return 16'($urandom_range(0, 40)) ^ 16'hA5A0;
    endfunction

    task automatic test_directed();
        send_request(OP_GET, 16'h0000, 32'h0);
        send_request(OP_UNLOAD, 16'hFFFF, 32'h0);
        send_request(OP_LOAD, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(OP_LOAD, 16'h0000, 32'h0000_0000);
        send_request(OP_LOAD, 16'h1234, 32'h0000_0000);
        send_request(OP_GET, 16'h1234, 32'h0);
        send_request(OP_LOAD, 16'hFFFF, 32'h0000_0005);
        send_request(OP_UNLOAD, 16'h0000, 32'h0);
        send_request(OP_GET, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(OP_GET, 16'h1234, 32'h0);
    endtask

    // Capacity 1, then 0 and 3, with all-ones stamps and ties
    task automatic test_small_capacity();
        write_capacity(7'd1);
        send_request(OP_LOAD, 16'h0001, 32'hFFFF_FFFF);
        send_request(OP_LOAD, 16'h0002, 32'hFFFF_FFFF);
        send_request(OP_LOAD, 16'h0003, 32'h0000_0001);
        write_capacity(7'd0);
        send_request(OP_LOAD, 16'h0004, 32'h8000_0000);
        write_capacity(7'd3);
        send_request(OP_LOAD, 16'h0005, 32'h7);
        send_request(OP_LOAD, 16'h0006, 32'h7);
        send_request(OP_LOAD, 16'h0007, 32'h7);
    endtask

    // Lower capacity below count: eviction keeps the count
    task automatic test_capacity_shrink();
        write_capacity(7'd8);
        for (int i = 0; i < 8; i++)
            send_request(OP_LOAD, 16'(16'h0100 + i), 32'($urandom()));
        write_capacity(7'd2);
        send_request(OP_LOAD, 16'h0200, 32'h1);
        send_request(OP_LOAD, 16'h0201, 32'h2);
        send_request(OP_CLEAR, 16'h0, 32'h0);
    endtask

    task automatic run_random(int n);
        int  r;
        op_t op;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            op = (r < 55) ? OP_LOAD : (r < 75) ? OP_GET : (r < 97) ? OP_UNLOAD : OP_CLEAR;
            send_request(op, pick_id(), 32'($urandom()));
        end
    endtask

    // Receiver stalls for a long stretch while requests keep coming
    task automatic test_backpressure();
        drain();
        hold_len = 1200;
        hold_off = 1'b1;
        run_random(15);
    endtask

    task automatic test_random();
        write_capacity(7'd64);
        run_random(200);
        write_capacity(7'd127);
        run_random(150);
        write_capacity(7'd5);
        run_random(120);
        write_capacity(7'd33);
        run_random(120);
    endtask

    initial
    begin
        errors    = 0;
        cycles    = 0;
        hold_off  = 1'b0;
        hold_len  = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        tbl_count = 0;
        tbl_cap   = CAP_RESET;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_small_capacity();
        test_capacity_shrink();
        test_backpressure();
        test_random();
        drain();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== lru_id_cache_table.f =====
hdl/lic_pkg.sv
hdl/lic_cell.sv
hdl/lru_id_cache_table.sv
sim/lru_id_cache_table_tb.sv
